// ----- hw/rtl/pdsp_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsp_pkg
// shared constants, state types and lane status for the divisor sum pair check
// ----------------------------------------------------------------------------
package pdsp_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned SUM_W    = 34;
  localparam int unsigned TOL_W    = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd2;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_TEST,
    LANE_DIV,
    LANE_DONE
  } lane_state_e;

  typedef enum logic {
    TOP_IDLE,
    TOP_RUN
  } top_state_e;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } lane_status_t;

endpackage

// ----- hw/rtl/proper_divisor_sum_pair_check_top.sv -----
// ----------------------------------------------------------------------------
// proper_divisor_sum_pair_check_top
// aliquot sums of a pair of values and a near-amicable flag
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o with first_i and second_i. a transfer
// starts one pair; in_stall_o stays high until its result is loaded.
// output channel: out_valid_o / out_stall_i with sum_first_o, sum_second_o
// and related_o, held in an output register while stalled.
// config channel: cfg_valid_i / cfg_ready_o with cfg_data_i, the tolerance.
// two lanes, one per value, each run trial division with a restoring divider.
// a value of 1 or less needs no trial divisors. a pair is done once both lanes
// are done, so the lane with more trial divisors sets when the pair finishes.
// a new pair is taken as soon as the previous result is in the output
// register, so it may run while that result waits behind a stall.
// reset clears all control state, empties the output register and sets the
// tolerance to 2.
// ----------------------------------------------------------------------------
module proper_divisor_sum_pair_check_top
  import pdsp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IN_W-1:0]   first_i,
  input  logic [IN_W-1:0]   second_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SUM_W-1:0]  sum_first_o,
  output logic [SUM_W-1:0]  sum_second_o,
  output logic              related_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TOL_W-1:0]  cfg_data_i
);

  localparam int unsigned W = VALUE_WIDTH;

  top_state_e          state_q, state_d;
  logic [TOL_W-1:0]    tol_q;
  logic signed [W-1:0] a_q, b_q;
  logic                start;
  logic                load;
  logic                space;
  lane_status_t        st_a, st_b;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != TOP_IDLE);
  assign start       = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    case (state_q)
      TOP_IDLE: begin
        if (start) begin
          state_d = TOP_RUN;
        end
      end
      TOP_RUN: begin
        if (st_a.done && st_b.done && space) begin
          load    = 1'b1;
          state_d = TOP_IDLE;
        end
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TOP_IDLE;
      tol_q   <= TOL_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q <= first_i[W-1:0];
      b_q <= second_i[W-1:0];
    end
  end

  pdsp_lane #(.W(W)) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .value_i  (first_i[W-1:0]),
    .status_o (st_a)
  );

  pdsp_lane #(.W(W)) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .value_i  (second_i[W-1:0]),
    .status_o (st_b)
  );

  pdsp_merge #(.W(W)) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .sum_a_i      (st_a.sum),
    .sum_b_i      (st_b.sum),
    .a_i          (a_q),
    .b_i          (b_q),
    .tol_i        (tol_q),
    .out_stall_i  (out_stall_i),
    .space_o      (space),
    .out_valid_o  (out_valid_o),
    .sum_first_o  (sum_first_o),
    .sum_second_o (sum_second_o),
    .related_o    (related_o)
  );

endmodule

// ----- hw/rtl/pdsp_div.sv -----
// ----------------------------------------------------------------------------
// pdsp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdsp_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned DW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      cnt_d = CW'(W);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[DW]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/pdsp_lane.sv -----
// ----------------------------------------------------------------------------
// pdsp_lane
// aliquot sum of one value by trial division with its own divider
// ----------------------------------------------------------------------------
module pdsp_lane
  import pdsp_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] value_i,
  output lane_status_t        status_o
);

  localparam int unsigned DW = (W + 2) / 2;
  localparam int unsigned SW = W + 1;

  lane_state_e      state_q, state_d;
  logic [W-1:0]     u_q, u_d;
  logic [DW-1:0]    i_q, i_d;
  logic [SW-1:0]    sq_q, sq_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             div_start;
  logic             div_done;
  logic [W-1:0]     div_quot;
  logic [DW-1:0]    div_rem;
  logic [SUM_W-1:0] co_add;

  pdsp_div #(
    .W  (W),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (u_q),
    .divisor_i  (i_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign co_add = (div_quot == W'(i_q)) ? '0 : SUM_W'(div_quot);

  always_comb begin
    state_d   = state_q;
    u_d       = u_q;
    i_d       = i_q;
    sq_d      = sq_q;
    sum_d     = sum_q;
    div_start = 1'b0;
    case (state_q)
      LANE_IDLE, LANE_DONE: begin
        if (start_i) begin
          u_d  = value_i;
          i_d  = DW'(2);
          sq_d = SW'(4);
          if (value_i <= $signed(W'(1))) begin
            sum_d   = '0;
            state_d = LANE_DONE;
          end else begin
            sum_d   = SUM_W'(1);
            state_d = LANE_TEST;
          end
        end
      end
      LANE_TEST: begin
        if (sq_q <= {1'b0, u_q}) begin
          div_start = 1'b1;
          state_d   = LANE_DIV;
        end else begin
          state_d = LANE_DONE;
        end
      end
      LANE_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            sum_d = sum_q + SUM_W'(i_q) + co_add;
          end
          i_d     = i_q + 1'b1;
          sq_d    = sq_q + SW'({i_q, 1'b1});
          state_d = LANE_TEST;
        end
      end
      default: state_d = LANE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LANE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    i_q   <= i_d;
    sq_q  <= sq_d;
    sum_q <= sum_d;
  end

  assign status_o.done = (state_q == LANE_DONE);
  assign status_o.sum  = sum_q;

endmodule

// ----- hw/rtl/pdsp_merge.sv -----
// ----------------------------------------------------------------------------
// pdsp_merge
// combines both lane sums into the result and holds it in the output register
// ----------------------------------------------------------------------------
module pdsp_merge
  import pdsp_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [SUM_W-1:0]    sum_a_i,
  input  logic [SUM_W-1:0]    sum_b_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  input  logic [TOL_W-1:0]    tol_i,
  input  logic                out_stall_i,
  output logic                space_o,
  output logic                out_valid_o,
  output logic [SUM_W-1:0]    sum_first_o,
  output logic [SUM_W-1:0]    sum_second_o,
  output logic                related_o
);

  localparam int unsigned DFW = SUM_W + 2;

  logic                  valid_q, valid_d;
  logic [SUM_W-1:0]      sa_q, sb_q;
  logic                  rel_q;
  logic signed [DFW-1:0] diff_a, diff_b;
  logic [DFW-1:0]        abs_a, abs_b;
  logic                  near_a, near_b;

  assign diff_a = $signed({2'b00, sum_a_i}) - DFW'(b_i);
  assign diff_b = $signed({2'b00, sum_b_i}) - DFW'(a_i);
  assign abs_a  = diff_a[DFW-1] ? DFW'(-diff_a) : DFW'(diff_a);
  assign abs_b  = diff_b[DFW-1] ? DFW'(-diff_b) : DFW'(diff_b);
  assign near_a = (abs_a <= DFW'(tol_i));
  assign near_b = (abs_b <= DFW'(tol_i));

  assign space_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sa_q  <= sum_a_i;
      sb_q  <= sum_b_i;
      rel_q <= near_a && near_b;
    end
  end

  assign out_valid_o  = valid_q;
  assign sum_first_o  = sa_q;
  assign sum_second_o = sb_q;
  assign related_o    = rel_q;

endmodule

// ----- bench/tb_proper_divisor_sum_pair_check_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_proper_divisor_sum_pair_check_top
// self-checking bench for the aliquot sum pair check
// ----------------------------------------------------------------------------
// pairs are driven through the valid/stall input channel and each result is
// compared field by field with a behavioral model of the aliquot sums and the
// tolerance flag. directed pairs cover values at most one, primes, squares,
// perfect and amicable numbers, the field extremes and the tolerance bounds.
// a long receiver hold-off fills the block, then random phases under several
// tolerance settings mix amicable and perfect pairs with small offsets,
// negative noise and small to medium values, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_proper_divisor_sum_pair_check_top;
  import pdsp_pkg::*;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [SUM_W-1:0] sum_first;
    logic [SUM_W-1:0] sum_second;
    logic             related;
  } pair_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [IN_W-1:0]  first_i;
  logic [IN_W-1:0]  second_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [SUM_W-1:0] sum_first_o;
  logic [SUM_W-1:0] sum_second_o;
  logic             related_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [TOL_W-1:0] cfg_data_i;

  pair_result_t     pair_results_q[$];
  logic [TOL_W-1:0] tol_model;
  int unsigned      errors;
  bit               burst;
  bit               hold_request;
  bit               hold_active;
  int unsigned      hold_len;

  int unsigned friend_lo [0:13] = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296,
                                    63020, 66928, 6, 28, 496, 8128};
  int unsigned friend_hi [0:13] = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416,
                                    76084, 66992, 6, 28, 496, 8128};

  proper_divisor_sum_pair_check_top #(
    .VALUE_WIDTH(VALUE_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .first_i     (first_i),
    .second_i    (second_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sum_first_o (sum_first_o),
    .sum_second_o(sum_second_o),
    .related_o   (related_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint signed_value(logic [IN_W-1:0] raw);
    logic [63:0] bits;
    bits = 64'(raw) & ((64'd1 << VALUE_W) - 64'd1);
    if (bits[VALUE_W-1]) begin
      bits = bits - (64'd1 << VALUE_W);
    end
    return longint'(bits);
  endfunction

  function automatic logic [SUM_W-1:0] aliquot_sum(longint n);
    longint unsigned u;
    longint unsigned i;
    longint unsigned total;
    if (n <= 1) begin
      return '0;
    end
    u = longint'(n);
    total = 1;
    for (i = 2; i * i <= u; i++) begin
      if (u % i == 0) begin
        total += i;
        if (u / i != i) begin
          total += u / i;
        end
      end
    end
    return total[SUM_W-1:0];
  endfunction

  function automatic bit within_tol(logic [SUM_W-1:0] s, longint other);
    longint d;
    d = longint'(64'(s)) - other;
    if (d < 0) begin
      d = -d;
    end
    return d <= longint'(64'(tol_model));
  endfunction

  function automatic pair_result_t predict_pair(logic [IN_W-1:0] a, logic [IN_W-1:0] b);
    pair_result_t r;
    longint va;
    longint vb;
    va = signed_value(a);
    vb = signed_value(b);
    r.sum_first  = aliquot_sum(va);
    r.sum_second = aliquot_sum(vb);
    r.related    = within_tol(r.sum_first, vb) && within_tol(r.sum_second, va);
    return r;
  endfunction

  // mostly short gaps, a few long ones, none in burst stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(25, 80);
  endfunction

  task automatic send_pair(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_i    <= a;
    second_i   <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pair_results_q.push_back(predict_pair(a, b));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pair_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    tol_model = value;
    @(posedge clk_i);
  endtask

  // values at most one, primes, squares, perfect and amicable numbers
  task automatic test_reset_tolerance();
    send_pair(0, 0);
    send_pair(-1, 1);
    send_pair(2, 2);
    send_pair(3, 3);
    send_pair(4, 4);
    send_pair(6, 6);
    send_pair(28, 28);
    send_pair(220, 284);
    send_pair(1184, 1210);
    wait_drain();
  endtask

  task automatic test_tolerance_bounds();
    write_tolerance(8'd0);
    send_pair(0, 0);
    send_pair(3, 3);
    send_pair(284, 220);
    send_pair(36, 36);
    wait_drain();
    write_tolerance(8'd1);
    send_pair(2, 2);
    send_pair(3, 3);
    send_pair(-1, 1);
    wait_drain();
    write_tolerance(8'd255);
    send_pair(1, 255);
    send_pair(1, 256);
    send_pair(49, 8);
    wait_drain();
  endtask

  task automatic test_extreme_values();
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    wait_drain();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    int k;
    hold_len     = 300;
    hold_request = 1'b1;
    while (!hold_active) @(posedge clk_i);
    burst = 1'b1;
    for (k = 0; k < 8; k++) begin
      send_pair(k, k + 2);
    end
    burst = 1'b0;
    wait_drain();
  endtask

  task automatic test_random_pairs();
    int          ph;
    int          k;
    int          a;
    int          b;
    int          swap_tmp;
    int unsigned idx;
    int unsigned r;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_tolerance(TOL_W'($urandom_range(0, 255)));
        end
        1: begin
          write_tolerance(8'd0);
        end
        2: begin
          write_tolerance(8'd255);
        end
        3: begin
          write_tolerance(TOL_W'($urandom_range(1, 16)));
        end
        default: begin
          write_tolerance(TOL_RESET);
        end
      endcase
      burst = (ph == 3);
      for (k = 0; k < 15; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          // amicable or perfect pair, sometimes nudged off by a few
          idx = $urandom_range(0, 13);
          a = friend_lo[idx];
          b = friend_hi[idx];
          if ($urandom_range(0, 1)) begin
            swap_tmp = a;
            a = b;
            b = swap_tmp;
          end
          if ($urandom_range(0, 1)) begin
            a = a + int'($urandom_range(0, 6)) - 3;
            b = b + int'($urandom_range(0, 6)) - 3;
          end
        end else if (r < 60) begin
          a = $urandom | 32'h8000_0000;
          b = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000) : $urandom_range(0, 3);
          if ($urandom_range(0, 1)) begin
            swap_tmp = a;
            a = b;
            b = swap_tmp;
          end
        end else if (r < 90) begin
          a = $urandom_range(0, 5000);
          if ($urandom_range(0, 1)) begin
            b = int'(aliquot_sum(a)) + int'($urandom_range(0, 4)) - 2;
          end else begin
            b = $urandom_range(0, 5000);
          end
        end else begin
          a = $urandom_range(0, 1 << 18);
          b = $urandom_range(0, 1 << 18);
        end
        send_pair(a, b);
      end
      burst = 1'b0;
      wait_drain();
    end
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_active = 1'b0;
      end else begin
        hold_len = pick_gap();
        if (hold_len > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold_len) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    pair_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pair_results_q.size() == 0) begin
        $error("result transfer with no pair pending");
        errors++;
      end else begin
        want = pair_results_q.pop_front();
        if (sum_first_o !== want.sum_first) begin
          $error("sum_first: expected %0d, got %0d", want.sum_first, sum_first_o);
          errors++;
        end
        if (sum_second_o !== want.sum_second) begin
          $error("sum_second: expected %0d, got %0d", want.sum_second, sum_second_o);
          errors++;
        end
        if (related_o !== want.related) begin
          $error("related: expected %0d, got %0d", want.related, related_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #150_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    errors       = 0;
    burst        = 1'b0;
    hold_request = 1'b0;
    hold_active  = 1'b0;
    tol_model    = TOL_RESET;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    first_i     <= '0;
    second_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_tolerance();
    test_tolerance_bounds();
    test_backpressure();
    test_random_pairs();
    test_extreme_values();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
